// ===== design/text_console_writer_unit_macros.svh =====
// assertion helpers shared by the checking code
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TCW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define TCW_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console assertion failed");

`endif

// ===== design/tcw_pkg.sv =====
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [COL_W-1:0] COLUMNS_C  = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0] ROWS_C     = ROW_W'(ROWS);
  localparam logic [ROW_W-1:0] LAST_ROW_C = ROW_W'(ROWS - 1);

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;

  localparam logic [1:0] MODE_PRINT = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } ram_wr_t;

endpackage

// ===== design/tcw_ifs.sv =====
interface tcw_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic [7:0]                char_byte;
  logic [tcw_pkg::ROW_W-1:0] read_row;
  logic [tcw_pkg::COL_W-1:0] read_column;

  modport source (output valid, mode, char_byte, read_row, read_column, input ready);
  modport sink   (input valid, mode, char_byte, read_row, read_column, output ready);
endinterface

interface tcw_out_if;
  logic                      valid;
  logic                      ready;
  logic [7:0]                cell_char;
  logic [7:0]                cell_attribute;
  logic [tcw_pkg::ROW_W-1:0] cursor_row_now;
  logic [tcw_pkg::COL_W-1:0] cursor_column_now;
  logic                      did_scroll;
  logic                      bad_address;

  modport source (output valid, cell_char, cell_attribute, cursor_row_now,
                  cursor_column_now, did_scroll, bad_address, input ready);
  modport sink   (input valid, cell_char, cell_attribute, cursor_row_now,
                  cursor_column_now, did_scroll, bad_address, output ready);
endinterface

interface tcw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tcw_pkg::CFG_IDX_W-1:0]  index;
  logic [tcw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/tcw_cell_ram.sv =====
module tcw_cell_ram (
  input  logic                               clk,
  input  tcw_pkg::ram_wr_t                   wr,
  input  logic [tcw_pkg::ADDR_W-1:0]         rd_addr,
  output logic [tcw_pkg::CELL_W-1:0]         rd_data
);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/text_console_writer_unit.sv =====
// print, backspace, plain newline, mode 3 and bad reads: result is registered from the execute state
// good reads pass through the read state first (registered read port of the cell store)
// a scroll sweeps COLUMNS cells and a clear CELL_COUNT cells, one cell write per cycle
// items do not overlap: each is accepted in idle, then executed, and in_ready stays low until it is done
// after reset a blanking pass over all CELL_COUNT (2000) cells runs with in_ready low;
// cursor, scroll base and colors reset to row 0, column 0, white on black
`include "text_console_writer_unit_macros.svh"

module text_console_writer_unit (
  input  logic clk,
  input  logic rst_n,
  tcw_in_if.sink    in_ch,
  tcw_out_if.source out_ch,
  tcw_cfg_if.sink   cfg_ch
);

  localparam int ADDR_W = tcw_pkg::ADDR_W;
  localparam int CNT_W  = tcw_pkg::CNT_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;
  localparam int COL_W  = tcw_pkg::COL_W;

  // rows live in a ring: logical row r sits at physical row (r + base) mod ROWS,
  // so a scroll is a base bump plus one row blank instead of a full copy
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] base);
    logic [ROW_W:0] sum;
    logic [ROW_W:0] rows_ext;
    rows_ext = {1'b0, tcw_pkg::ROWS_C};
    sum = {1'b0, row} + {1'b0, base};
    if (sum >= rows_ext) begin
      sum = sum - rows_ext;
    end
    return ADDR_W'(sum) * ADDR_W'(tcw_pkg::COLUMNS) + ADDR_W'(col);
  endfunction

  tcw_pkg::state_t state_r, state_nxt;

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] base_r, base_nxt;
  logic [3:0]       fg_r, fg_nxt;
  logic [3:0]       bg_r, bg_nxt;

  // latched item
  logic [1:0]       mode_r, mode_nxt;
  logic [7:0]       char_r, char_nxt;
  logic [ROW_W-1:0] rr_r, rr_nxt;
  logic [COL_W-1:0] rc_r, rc_nxt;

  // sweep sequencer
  logic [ADDR_W-1:0] sweep_addr_r, sweep_addr_nxt;
  logic [CNT_W-1:0]  sweep_left_r, sweep_left_nxt;
  logic              put_char_r, put_char_nxt;
  logic              scrolled_r, scrolled_nxt;

  // result parked while the output register is still full
  logic [7:0] res_char_r, res_char_nxt;
  logic [7:0] res_attr_r, res_attr_nxt;
  logic       res_scroll_r, res_scroll_nxt;
  logic       res_bad_r, res_bad_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic [7:0]       out_attr_r, out_attr_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic             out_scroll_r, out_scroll_nxt;
  logic             out_bad_r, out_bad_nxt;

  // finish request from the sequencer
  logic       fin_req;
  logic [7:0] fin_char;
  logic [7:0] fin_attr;
  logic       fin_scroll;
  logic       fin_bad;

  logic                       slot_free;
  logic [7:0]                 attr;
  logic                       read_bad;
  logic [ADDR_W-1:0]          rd_addr;
  logic [tcw_pkg::CELL_W-1:0] rd_data;
  tcw_pkg::ram_wr_t           wr;

  tcw_cell_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign attr      = {bg_r, fg_r};
  assign slot_free = !out_valid_r || out_ch.ready;
  assign read_bad  = (rr_r >= tcw_pkg::ROWS_C) || (rc_r >= tcw_pkg::COLUMNS_C);
  // only looked at when the read is in range
  assign rd_addr   = cell_addr(rr_r, rc_r, base_r);

  assign in_ch.ready  = (state_r == tcw_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid             = out_valid_r;
  assign out_ch.cell_char         = out_char_r;
  assign out_ch.cell_attribute    = out_attr_r;
  assign out_ch.cursor_row_now    = out_row_r;
  assign out_ch.cursor_column_now = out_col_r;
  assign out_ch.did_scroll        = out_scroll_r;
  assign out_ch.bad_address       = out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tcw_pkg::ST_INIT;
      row_r        <= '0;
      col_r        <= '0;
      base_r       <= '0;
      fg_r         <= 4'hF;
      bg_r         <= 4'h0;
      sweep_addr_r <= '0;
      sweep_left_r <= '0;
      put_char_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      base_r       <= base_nxt;
      fg_r         <= fg_nxt;
      bg_r         <= bg_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_left_r <= sweep_left_nxt;
      put_char_r   <= put_char_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    char_r       <= char_nxt;
    rr_r         <= rr_nxt;
    rc_r         <= rc_nxt;
    scrolled_r   <= scrolled_nxt;
    res_char_r   <= res_char_nxt;
    res_attr_r   <= res_attr_nxt;
    res_scroll_r <= res_scroll_nxt;
    res_bad_r    <= res_bad_nxt;
    out_char_r   <= out_char_nxt;
    out_attr_r   <= out_attr_nxt;
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_scroll_r <= out_scroll_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    base_nxt       = base_r;
    fg_nxt         = fg_r;
    bg_nxt         = bg_r;
    mode_nxt       = mode_r;
    char_nxt       = char_r;
    rr_nxt         = rr_r;
    rc_nxt         = rc_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_left_nxt = sweep_left_r;
    put_char_nxt   = put_char_r;
    scrolled_nxt   = scrolled_r;
    res_char_nxt   = res_char_r;
    res_attr_nxt   = res_attr_r;
    res_scroll_nxt = res_scroll_r;
    res_bad_nxt    = res_bad_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_char_nxt   = out_char_r;
    out_attr_nxt   = out_attr_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_scroll_nxt = out_scroll_r;
    out_bad_nxt    = out_bad_r;

    wr         = '0;
    fin_req    = 1'b0;
    fin_char   = 8'd0;
    fin_attr   = 8'd0;
    fin_scroll = 1'b0;
    fin_bad    = 1'b0;

    // color registers, to be written by the user only while idle; the block itself does not enforce this
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tcw_pkg::REG_FOREGROUND: fg_nxt = cfg_ch.data[3:0];
        tcw_pkg::REG_BACKGROUND: bg_nxt = cfg_ch.data[3:0];
        default: ;
      endcase
    end

    case (state_r)
      tcw_pkg::ST_INIT: begin
        // power-up blanking pass with the reset colors
        wr.en          = 1'b1;
        wr.addr        = sweep_addr_r;
        wr.data        = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_SPACE};
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        if (sweep_addr_r == ADDR_W'(tcw_pkg::CELL_COUNT - 1)) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end

      tcw_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt  = in_ch.mode;
          char_nxt  = in_ch.char_byte;
          rr_nxt    = in_ch.read_row;
          rc_nxt    = in_ch.read_column;
          state_nxt = tcw_pkg::ST_EXEC;
        end
      end

      tcw_pkg::ST_EXEC: begin
        case (mode_r)
          tcw_pkg::MODE_PRINT: begin
            if (char_r == tcw_pkg::CH_NEWLINE) begin
              col_nxt = '0;
              if (row_r < tcw_pkg::LAST_ROW_C) begin
                row_nxt = row_r + 1'b1;
                fin_req = 1'b1;
              end else begin
                // old top row becomes the new last row: blank it
                base_nxt       = (base_r == tcw_pkg::LAST_ROW_C) ? '0 : base_r + 1'b1;
                sweep_addr_nxt = ADDR_W'(base_r) * ADDR_W'(tcw_pkg::COLUMNS);
                sweep_left_nxt = CNT_W'(tcw_pkg::COLUMNS);
                put_char_nxt   = 1'b0;
                scrolled_nxt   = 1'b1;
                state_nxt      = tcw_pkg::ST_SWEEP;
              end
            end else if (char_r == tcw_pkg::CH_BACKSPACE) begin
              if (col_r != '0) begin
                col_nxt = col_r - 1'b1;
                wr.en   = 1'b1;
                wr.addr = cell_addr(row_r, col_r - 1'b1, base_r);
                wr.data = {attr, tcw_pkg::CH_SPACE};
              end
              fin_req = 1'b1;
            end else if (col_r >= tcw_pkg::COLUMNS_C) begin
              // pending wrap before the character lands
              col_nxt = COL_W'(1);
              if (row_r < tcw_pkg::LAST_ROW_C) begin
                row_nxt = row_r + 1'b1;
                wr.en   = 1'b1;
                wr.addr = cell_addr(row_r + 1'b1, '0, base_r);
                wr.data = {attr, char_r};
                fin_req = 1'b1;
              end else begin
                // scroll, char goes in the first cell of the blanked row
                base_nxt       = (base_r == tcw_pkg::LAST_ROW_C) ? '0 : base_r + 1'b1;
                sweep_addr_nxt = ADDR_W'(base_r) * ADDR_W'(tcw_pkg::COLUMNS);
                sweep_left_nxt = CNT_W'(tcw_pkg::COLUMNS);
                put_char_nxt   = 1'b1;
                scrolled_nxt   = 1'b1;
                state_nxt      = tcw_pkg::ST_SWEEP;
              end
            end else begin
              wr.en   = 1'b1;
              wr.addr = cell_addr(row_r, col_r, base_r);
              wr.data = {attr, char_r};
              col_nxt = col_r + 1'b1;
              fin_req = 1'b1;
            end
          end

          tcw_pkg::MODE_CLEAR: begin
            sweep_addr_nxt = '0;
            sweep_left_nxt = CNT_W'(tcw_pkg::CELL_COUNT);
            put_char_nxt   = 1'b0;
            scrolled_nxt   = 1'b0;
            state_nxt      = tcw_pkg::ST_SWEEP;
          end

          tcw_pkg::MODE_READ: begin
            if (read_bad) begin
              fin_char = tcw_pkg::CH_SPACE;
              fin_bad  = 1'b1;
              fin_req  = 1'b1;
            end else begin
              state_nxt = tcw_pkg::ST_READ;
            end
          end

          default: begin
            fin_req = 1'b1;
          end
        endcase
      end

      tcw_pkg::ST_SWEEP: begin
        wr.en          = 1'b1;
        wr.addr        = sweep_addr_r;
        wr.data        = {attr, put_char_r ? char_r : tcw_pkg::CH_SPACE};
        put_char_nxt   = 1'b0;
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        sweep_left_nxt = sweep_left_r - 1'b1;
        if (sweep_left_r == CNT_W'(1)) begin
          fin_scroll = scrolled_r;
          fin_req    = 1'b1;
        end
      end

      tcw_pkg::ST_READ: begin
        fin_char = rd_data[7:0];
        fin_attr = rd_data[15:8];
        fin_req  = 1'b1;
      end

      tcw_pkg::ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = res_char_r;
          out_attr_nxt   = res_attr_r;
          out_row_nxt    = row_r;
          out_col_nxt    = col_r;
          out_scroll_nxt = res_scroll_r;
          out_bad_nxt    = res_bad_r;
          state_nxt      = tcw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase

    // hand the result over, or park it until the output register drains
    if (fin_req) begin
      if (slot_free) begin
        out_valid_nxt  = 1'b1;
        out_char_nxt   = fin_char;
        out_attr_nxt   = fin_attr;
        out_row_nxt    = row_nxt;
        out_col_nxt    = col_nxt;
        out_scroll_nxt = fin_scroll;
        out_bad_nxt    = fin_bad;
        state_nxt      = tcw_pkg::ST_IDLE;
      end else begin
        res_char_nxt   = fin_char;
        res_attr_nxt   = fin_attr;
        res_scroll_nxt = fin_scroll;
        res_bad_nxt    = fin_bad;
        state_nxt      = tcw_pkg::ST_DONE;
      end
    end
  end

  // cursor may sit one past the last column (wrap pending), never further
  `TCW_ASSERT_IMP(a_cursor_range, 1'b1, (col_r <= tcw_pkg::COLUMNS_C) && (row_r < tcw_pkg::ROWS_C))
  // scroll base always names a real row
  `TCW_ASSERT_IMP(a_base_range, 1'b1, base_r < tcw_pkg::ROWS_C)
  // an accepted transfer always starts execution next cycle
  `TCW_ASSERT_NXT(a_accept_exec, in_ch.valid && in_ch.ready, state_r == tcw_pkg::ST_EXEC)
  // every sweep and power-up blanking cycle writes one cell
  `TCW_ASSERT_IMP(a_sweep_writes, (state_r == tcw_pkg::ST_SWEEP) || (state_r == tcw_pkg::ST_INIT), wr.en)

endmodule
